// ===== src/qrs_pkg.sv =====
// Shared constants and types for the quadratic root solver.
`default_nettype none

package qrs_pkg;

  // Default coefficient and result formats
  localparam int COEF_WIDTH = 16;
  localparam int COEF_FRAC  = 8;
  localparam int OUT_WIDTH  = 32;

  // Fraction bits of every result and guard bits kept by the square root
  localparam int OUT_FRAC   = 16;
  localparam int GUARD_BITS = OUT_FRAC - 1;

  // Division lanes: one per numeric result
  localparam int LANES       = 5;
  localparam int LANE_FIRST  = 0;
  localparam int LANE_SECOND = 1;
  localparam int LANE_H      = 2;
  localparam int LANE_K      = 3;
  localparam int LANE_PROD   = 4;

  // Root classification codes
  typedef enum logic [1:0] {
    CLS_TWO_REAL = 2'd0,
    CLS_DOUBLE   = 2'd1,
    CLS_COMPLEX  = 2'd2
  } root_class_t;

endpackage

`default_nettype wire

// ===== src/qrs_coef_if.sv =====
// Coefficient request channel: valid, ready and the three Q-format coefficients.
`default_nettype none

interface qrs_coef_if #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

`default_nettype wire

// ===== src/qrs_root_if.sv =====
// Result channel: valid, ready, root class, the five numeric results and two flags.
`default_nettype none

interface qrs_root_if #(
  parameter int OUT_WIDTH = qrs_pkg::OUT_WIDTH
) ();
  logic                        valid;
  logic                        ready;
  qrs_pkg::root_class_t        root_class;
  logic signed [OUT_WIDTH-1:0] first_value;
  logic signed [OUT_WIDTH-1:0] second_value;
  logic signed [OUT_WIDTH-1:0] vertex_h;
  logic signed [OUT_WIDTH-1:0] vertex_k;
  logic signed [OUT_WIDTH-1:0] root_product;
  logic                        degenerate;
  logic                        saturated;

  modport source (
    output valid, output root_class, output first_value, output second_value,
    output vertex_h, output vertex_k, output root_product, output degenerate,
    output saturated, input ready
  );
  modport sink (
    input valid, input root_class, input first_value, input second_value,
    input vertex_h, input vertex_k, input root_product, input degenerate,
    input saturated, output ready
  );
endinterface

`default_nettype wire

// ===== src/qrs_sqrt_cell.sv =====
// One bit of a pipelined integer square root: shift in two radicand bits, trial subtract.
`default_nettype none

module qrs_sqrt_cell #(
  parameter int SW   = 32,
  parameter int TAGW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*SW-1:0]   in_x,
  input  logic [SW+1:0]     in_rem,
  input  logic [SW-1:0]     in_root,
  input  logic [TAGW-1:0]   in_tag,
  output logic              out_valid,
  output logic [2*SW-1:0]   out_x,
  output logic [SW+1:0]     out_rem,
  output logic [SW-1:0]     out_root,
  output logic [TAGW-1:0]   out_tag
);

  logic [SW+1:0]   shifted;
  logic [SW+1:0]   trial;
  logic            fits;
  logic [SW+1:0]   rem_next;
  logic [SW-1:0]   root_next;
  logic [2*SW-1:0] x_next;

  // Bring down the next radicand pair and try root*4+1
  always_comb begin
    shifted   = {in_rem[SW-1:0], in_x[2*SW-1 -: 2]};
    trial     = {in_root, 2'b01};
    fits      = shifted >= trial;
    rem_next  = fits ? (shifted - trial) : shifted;
    root_next = {in_root[SW-2:0], fits};
    x_next    = {in_x[2*SW-3:0], 2'b00};
  end

  // Advance valid under reset control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= x_next;
      out_rem  <= rem_next;
      out_root <= root_next;
      out_tag  <= in_tag;
    end
  end

endmodule

`default_nettype wire

// ===== src/qrs_div_cell.sv =====
// One quotient bit of a pipelined restoring divider, applied to every lane at once.
`default_nettype none

module qrs_div_cell #(
  parameter int LANES = 5,
  parameter int DENW  = 18,
  parameter int OW    = 32,
  parameter int TAGW  = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][DENW-1:0]  in_rem,
  input  logic [LANES-1:0][OW-1:0]    in_word,
  input  logic [LANES-1:0][DENW-1:0]  in_den,
  input  logic [TAGW-1:0]             in_tag,
  output logic                        out_valid,
  output logic [LANES-1:0][DENW-1:0]  out_rem,
  output logic [LANES-1:0][OW-1:0]    out_word,
  output logic [LANES-1:0][DENW-1:0]  out_den,
  output logic [TAGW-1:0]             out_tag
);

  logic [LANES-1:0][DENW-1:0] rem_next;
  logic [LANES-1:0][OW-1:0]   word_next;

  // Shift the next numerator bit into the remainder, subtract when it fits;
  // the quotient bit enters the word from the bottom as numerator bits leave the top
  always_comb begin
    logic [DENW:0] trial;
    logic [DENW:0] den_x;
    logic          fits;
    for (int l = 0; l < LANES; l++) begin
      trial        = {in_rem[l], in_word[l][OW-1]};
      den_x        = {1'b0, in_den[l]};
      fits         = trial >= den_x;
      rem_next[l]  = fits ? DENW'(trial - den_x) : DENW'(trial);
      word_next[l] = {in_word[l][OW-2:0], fits};
    end
  end

  // Advance valid under reset control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_word <= word_next;
      out_den  <= in_den;
      out_tag  <= in_tag;
    end
  end

endmodule

`default_nettype wire

// ===== src/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: discriminant, square root chain, divider chain.
//
//   channel  role    handshake      payload
//   coef     sink    valid/ready    coef_a, coef_b, coef_c (signed, COEF_FRAC fraction bits)
//   roots    source  valid/ready    root_class, first_value, second_value, vertex_h,
//                                   vertex_k, root_product, degenerate, saturated
//
// One request is accepted per cycle unless the pipeline holds; a request passes through the
// products and discriminant registers, one square root cell per root bit, the divider
// setup registers, one divider cell per quotient bit and the output register. Reset
// clears only the valid bits. When a result waits in the output register and
// roots.ready is low, the whole pipeline holds and coef.ready drops.
`default_nettype none

module quadratic_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
  parameter int COEF_FRAC  = qrs_pkg::COEF_FRAC,
  parameter int OUT_WIDTH  = qrs_pkg::OUT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  qrs_coef_if.sink    coef,
  qrs_root_if.source  roots
);

  localparam int CW    = COEF_WIDTH;
  localparam int CF    = COEF_FRAC;
  localparam int OW    = OUT_WIDTH;
  localparam int OF    = qrs_pkg::OUT_FRAC;
  localparam int G     = qrs_pkg::GUARD_BITS;
  localparam int LANES = qrs_pkg::LANES;
  localparam int PW    = 2 * CW;                 // coefficient products
  localparam int DW    = 2 * CW + 2;             // discriminant, signed
  localparam int SW    = CW + 1 + G;             // square root result
  localparam int NW    = 2 * CW + OF + 3;        // signed numerators
  localparam int MW    = (NW > OW) ? NW : OW + 1; // rounded numerator magnitude
  localparam int DENW  = CW + 2;                 // divisor magnitude (up to 4|a|)
  localparam int CMPW  = MW + DENW;
  localparam int STAGW = 3 * CW + DW;            // tag through the root chain
  localparam int DTAGW = 3 + 2 * LANES;          // tag through the divider chain

  localparam logic [OW-1:0] MAX_VAL = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] MIN_VAL = {1'b1, {(OW-1){1'b0}}};

  logic adv;

  // Hold everything while a finished result waits
  assign adv        = !roots.valid || roots.ready;
  assign coef.ready = adv;

  // ---------------- Stage 1: products ----------------
  logic                 v1;
  logic signed [CW-1:0] a1, b1, c1;
  logic signed [PW-1:0] bb1, ac1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= coef.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1  <= coef.coef_a;
      b1  <= coef.coef_b;
      c1  <= coef.coef_c;
      bb1 <= PW'(coef.coef_b) * PW'(coef.coef_b);
      ac1 <= PW'(coef.coef_a) * PW'(coef.coef_c);
    end
  end

  // ---------------- Stage 2: discriminant ----------------
  logic                 v2;
  logic signed [CW-1:0] a2, b2, c2;
  logic signed [DW-1:0] d2;
  logic [2*SW-1:0]      x2;
  logic signed [DW-1:0] d_calc;
  logic [DW-1:0]        d_mag;

  always_comb begin
    d_calc = DW'(bb1) - (DW'(ac1) <<< 2);
    d_mag  = d_calc[DW-1] ? DW'(-d_calc) : DW'(d_calc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2 <= a1;
      b2 <= b1;
      c2 <= c1;
      d2 <= d_calc;
      x2 <= {d_mag, {(2*G){1'b0}}};
    end
  end

  // ---------------- Square root chain ----------------
  logic              sq_v    [0:SW];
  logic [2*SW-1:0]   sq_x    [0:SW];
  logic [SW+1:0]     sq_rem  [0:SW];
  logic [SW-1:0]     sq_root [0:SW];
  logic [STAGW-1:0]  sq_tag  [0:SW];

  assign sq_v[0]    = v2;
  assign sq_x[0]    = x2;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_tag[0]  = {a2, b2, c2, d2};

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(
      .SW   (SW),
      .TAGW (STAGW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (sq_v[i]),
      .in_x      (sq_x[i]),
      .in_rem    (sq_rem[i]),
      .in_root   (sq_root[i]),
      .in_tag    (sq_tag[i]),
      .out_valid (sq_v[i+1]),
      .out_x     (sq_x[i+1]),
      .out_rem   (sq_rem[i+1]),
      .out_root  (sq_root[i+1]),
      .out_tag   (sq_tag[i+1])
    );
  end

  // ---------------- Setup 1: numerators and divisors per lane ----------------
  logic signed [CW-1:0] ta, tb, tc;
  logic signed [DW-1:0] td;
  logic [SW-1:0]        ts;

  assign ta = sq_tag[SW][STAGW-1 -: CW];
  assign tb = sq_tag[SW][STAGW-CW-1 -: CW];
  assign tc = sq_tag[SW][STAGW-2*CW-1 -: CW];
  assign td = sq_tag[SW][DW-1:0];
  assign ts = sq_root[SW];

  qrs_pkg::root_class_t       cls_calc;
  logic signed [NW-1:0]       num_calc  [LANES];
  logic [DENW-1:0]            dmag_calc [LANES];
  logic                       dneg_calc [LANES];

  always_comb begin
    logic signed [NW-1:0]   bx, sx, nb, nh;
    logic signed [DENW-1:0] ax;
    logic [DENW-1:0]        amag;
    logic                   aneg;
    bx   = NW'(tb);
    sx   = NW'(ts);
    nb   = -(bx <<< G);
    nh   = -(bx <<< OF);
    ax   = DENW'(ta);
    aneg = ta[CW-1];
    amag = aneg ? DENW'(-ax) : DENW'(ax);

    // Classify by the sign of the discriminant
    priority if (!td[DW-1] && td != '0) begin
      cls_calc = qrs_pkg::CLS_TWO_REAL;
    end else if (td == '0) begin
      cls_calc = qrs_pkg::CLS_DOUBLE;
    end else begin
      cls_calc = qrs_pkg::CLS_COMPLEX;
    end

    // Vertex abscissa: -b over 2a
    num_calc[qrs_pkg::LANE_H]  = nh;
    dmag_calc[qrs_pkg::LANE_H] = amag << 1;
    dneg_calc[qrs_pkg::LANE_H] = aneg;

    // Vertex ordinate: -D over 4a
    num_calc[qrs_pkg::LANE_K]  = -(NW'(td) <<< (OF - CF));
    dmag_calc[qrs_pkg::LANE_K] = amag << 2;
    dneg_calc[qrs_pkg::LANE_K] = aneg;

    // Root product: c over a
    num_calc[qrs_pkg::LANE_PROD]  = NW'(tc) <<< OF;
    dmag_calc[qrs_pkg::LANE_PROD] = amag;
    dneg_calc[qrs_pkg::LANE_PROD] = aneg;

    // First root, the double root, or the real part
    num_calc[qrs_pkg::LANE_FIRST]  = (cls_calc == qrs_pkg::CLS_TWO_REAL) ?
                                     ((nb + sx) <<< (OF - G)) : nh;
    dmag_calc[qrs_pkg::LANE_FIRST] = amag << 1;
    dneg_calc[qrs_pkg::LANE_FIRST] = aneg;

    // Second root, the double root again, or the imaginary part over |2a|
    unique case (cls_calc)
      qrs_pkg::CLS_TWO_REAL: begin
        num_calc[qrs_pkg::LANE_SECOND]  = (nb - sx) <<< (OF - G);
        dneg_calc[qrs_pkg::LANE_SECOND] = aneg;
      end
      qrs_pkg::CLS_DOUBLE: begin
        num_calc[qrs_pkg::LANE_SECOND]  = nh;
        dneg_calc[qrs_pkg::LANE_SECOND] = aneg;
      end
      default: begin
        num_calc[qrs_pkg::LANE_SECOND]  = sx <<< (OF - G);
        dneg_calc[qrs_pkg::LANE_SECOND] = 1'b0;
      end
    endcase
    dmag_calc[qrs_pkg::LANE_SECOND] = amag << 1;
  end

  logic                  v3;
  qrs_pkg::root_class_t  cls3;
  logic                  degen3;
  logic signed [NW-1:0]  num3  [LANES];
  logic [DENW-1:0]       dmag3 [LANES];
  logic                  dneg3 [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= sq_v[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls3   <= cls_calc;
      degen3 <= (ta == '0);
      num3   <= num_calc;
      dmag3  <= dmag_calc;
      dneg3  <= dneg_calc;
    end
  end

  // ---------------- Setup 2: magnitude plus half divisor ----------------
  logic                  v4;
  qrs_pkg::root_class_t  cls4;
  logic                  degen4;
  logic [MW-1:0]         mag4  [LANES];
  logic [DENW-1:0]       dmag4 [LANES];
  logic                  neg4  [LANES];
  logic [MW-1:0]         mag_calc [LANES];

  always_comb begin
    logic [MW-1:0] half;
    for (int l = 0; l < LANES; l++) begin
      half        = MW'(dmag3[l] >> 1);
      mag_calc[l] = num3[l][NW-1] ? (half - MW'(num3[l])) : (MW'(num3[l]) + half);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls4   <= cls3;
      degen4 <= degen3;
      mag4   <= mag_calc;
      dmag4  <= dmag3;
      for (int l = 0; l < LANES; l++) begin
        neg4[l] <= num3[l][NW-1] ^ dneg3[l];
      end
    end
  end

  // ---------------- Setup 3: overflow check and divider load ----------------
  logic                        v5;
  logic [LANES-1:0][DENW-1:0]  rem5;
  logic [LANES-1:0][OW-1:0]    word5;
  logic [LANES-1:0][DENW-1:0]  den5;
  logic [DTAGW-1:0]            tag5;
  logic [LANES-1:0]            ovf_calc;
  logic [LANES-1:0][DENW-1:0]  rem_calc;
  logic [LANES-1:0]            neg_vec;

  always_comb begin
    logic [CMPW-1:0] mag_w;
    for (int l = 0; l < LANES; l++) begin
      mag_w       = CMPW'(mag4[l]);
      ovf_calc[l] = mag_w >= (CMPW'(dmag4[l]) << OW);
      rem_calc[l] = DENW'(mag_w >> OW);
      neg_vec[l]  = neg4[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem5 <= rem_calc;
      for (int l = 0; l < LANES; l++) begin
        word5[l] <= mag4[l][OW-1:0];
        den5[l]  <= dmag4[l];
      end
      tag5 <= {cls4, degen4, neg_vec, ovf_calc};
    end
  end

  // ---------------- Divider chain ----------------
  logic                        dv_v    [0:OW];
  logic [LANES-1:0][DENW-1:0]  dv_rem  [0:OW];
  logic [LANES-1:0][OW-1:0]    dv_word [0:OW];
  logic [LANES-1:0][DENW-1:0]  dv_den  [0:OW];
  logic [DTAGW-1:0]            dv_tag  [0:OW];

  assign dv_v[0]    = v5;
  assign dv_rem[0]  = rem5;
  assign dv_word[0] = word5;
  assign dv_den[0]  = den5;
  assign dv_tag[0]  = tag5;

  for (genvar i = 0; i < OW; i++) begin : g_div
    qrs_div_cell #(
      .LANES (LANES),
      .DENW  (DENW),
      .OW    (OW),
      .TAGW  (DTAGW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (dv_v[i]),
      .in_rem    (dv_rem[i]),
      .in_word   (dv_word[i]),
      .in_den    (dv_den[i]),
      .in_tag    (dv_tag[i]),
      .out_valid (dv_v[i+1]),
      .out_rem   (dv_rem[i+1]),
      .out_word  (dv_word[i+1]),
      .out_den   (dv_den[i+1]),
      .out_tag   (dv_tag[i+1])
    );
  end

  // ---------------- Saturate, sign and register the result ----------------
  qrs_pkg::root_class_t   cls_f;
  logic                   degen_f;
  logic [LANES-1:0]       neg_f, ovf_f, clip_f;
  logic [LANES-1:0][OW-1:0] val_f;

  assign cls_f   = qrs_pkg::root_class_t'(dv_tag[OW][DTAGW-1 -: 2]);
  assign degen_f = dv_tag[OW][2*LANES];
  assign neg_f   = dv_tag[OW][2*LANES-1 -: LANES];
  assign ovf_f   = dv_tag[OW][LANES-1:0];

  always_comb begin
    logic [OW-1:0] q;
    for (int l = 0; l < LANES; l++) begin
      q         = dv_word[OW][l];
      clip_f[l] = !degen_f &&
                  (ovf_f[l] || (q[OW-1] && (!neg_f[l] || (q[OW-2:0] != '0))));
      if (degen_f) begin
        val_f[l] = '0;
      end else if (clip_f[l]) begin
        val_f[l] = neg_f[l] ? MIN_VAL : MAX_VAL;
      end else begin
        val_f[l] = neg_f[l] ? (~q + 1'b1) : q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roots.valid <= 1'b0;
    end else if (adv) begin
      roots.valid <= dv_v[OW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roots.root_class   <= degen_f ? qrs_pkg::CLS_TWO_REAL : cls_f;
      roots.first_value  <= val_f[qrs_pkg::LANE_FIRST];
      roots.second_value <= val_f[qrs_pkg::LANE_SECOND];
      roots.vertex_h     <= val_f[qrs_pkg::LANE_H];
      roots.vertex_k     <= val_f[qrs_pkg::LANE_K];
      roots.root_product <= val_f[qrs_pkg::LANE_PROD];
      roots.degenerate   <= degen_f;
      roots.saturated    <= |clip_f;
    end
  end

  // ---------------- Assertions ----------------
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.degenerate |->
      roots.first_value == '0 && roots.second_value == '0 && roots.vertex_h == '0 &&
      roots.vertex_k == '0 && roots.root_product == '0 && !roots.saturated &&
      roots.root_class == qrs_pkg::CLS_TWO_REAL)
    else $error("degenerate result carries nonzero fields");

  a_double_equal: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.root_class == qrs_pkg::CLS_DOUBLE |->
      roots.first_value == roots.second_value && roots.first_value == roots.vertex_h)
    else $error("double root halves differ");

  a_complex_imag: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.root_class == qrs_pkg::CLS_COMPLEX |->
      !roots.second_value[OW-1] && roots.first_value == roots.vertex_h)
    else $error("complex pair with negative imaginary part or bad real part");

  a_stall_input: assert property (@(posedge clk) disable iff (rst)
    roots.valid && !roots.ready |-> !coef.ready)
    else $error("request taken while the pipeline is held");

endmodule

`default_nettype wire
